>>> hdl/dbd_pkg.sv
package dbd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  // Ordinal day numbers up to year 16383 need one more bit than the count.
  localparam int unsigned ORD_W   = 23;
  localparam int unsigned DOY_W   = 9;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [YEAR_W-1:0]  MIN_YEAR = 14'd1;
  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 22'd3652058;

  // Quotient by 100 as multiply by ceil(2^20/100) and shift by 20; exact for all
  // 14-bit values because the rounding error times 2^14 stays below 2^20.
  localparam logic [YEAR_W-1:0]  RECIP_100   = 14'd10486;
  localparam int unsigned        RECIP_SHIFT = 20;
  localparam int unsigned        PROD_W      = 2 * YEAR_W;
  localparam int unsigned        QUOT_W      = 8;

  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

  // Stage load enables of the per-date pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } ord_en_t;

  // Days before the first of each month in a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dbd_ordinal.sv
module dbd_ordinal (
  input  logic                             clk,
  input  dbd_pkg::ord_en_t                 en,
  input  logic [dbd_pkg::YEAR_W-1:0]       year,
  input  logic [dbd_pkg::MONTH_W-1:0]      month,
  input  logic [dbd_pkg::DAY_W-1:0]        day,
  output logic [dbd_pkg::ORD_W-1:0]        ordinal,
  output logic                             date_ok
);

  // Stage 1: year minus one, and quotients by 100 of year and year minus one.
  logic [dbd_pkg::YEAR_W-1:0]  p_in;
  logic [dbd_pkg::PROD_W-1:0]  prod_y;
  logic [dbd_pkg::PROD_W-1:0]  prod_p;
  logic [dbd_pkg::YEAR_W-1:0]  y1_r;
  logic [dbd_pkg::YEAR_W-1:0]  p1_r;
  logic [dbd_pkg::MONTH_W-1:0] m1_r;
  logic [dbd_pkg::DAY_W-1:0]   d1_r;
  logic [dbd_pkg::QUOT_W-1:0]  qy1_r;
  logic [dbd_pkg::QUOT_W-1:0]  qp1_r;

  assign p_in   = year - dbd_pkg::MIN_YEAR;
  assign prod_y = year * dbd_pkg::RECIP_100;
  assign prod_p = p_in * dbd_pkg::RECIP_100;

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      y1_r  <= year;
      p1_r  <= p_in;
      m1_r  <= month;
      d1_r  <= day;
      qy1_r <= prod_y[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QUOT_W];
      qp1_r <= prod_p[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QUOT_W];
    end
  end

  // Stage 2: leap year, validity and day of year.
  logic [dbd_pkg::YEAR_W-1:0]  rem100;
  logic                        leap;
  logic [dbd_pkg::DAY_W-1:0]   mlen;
  logic                        ok_nxt;
  logic [dbd_pkg::DOY_W-1:0]   doy_nxt;
  logic [dbd_pkg::YEAR_W-1:0]  p2_r;
  logic [dbd_pkg::QUOT_W-1:0]  qp2_r;
  logic [dbd_pkg::DOY_W-1:0]   doy2_r;
  logic                        ok2_r;

  always_comb begin
    rem100 = y1_r - dbd_pkg::YEAR_W'(qy1_r) * 14'd100;
    leap   = ((y1_r[1:0] == 2'd0) && (rem100 != '0)) ||
             ((rem100 == '0) && (qy1_r[1:0] == 2'd0));
    if (m1_r == dbd_pkg::MONTH_FEB) begin
      mlen = leap ? 5'd29 : 5'd28;
    end else if (m1_r == dbd_pkg::MONTH_APR || m1_r == dbd_pkg::MONTH_JUN ||
                 m1_r == dbd_pkg::MONTH_SEP || m1_r == dbd_pkg::MONTH_NOV) begin
      mlen = 5'd30;
    end else begin
      mlen = 5'd31;
    end
    ok_nxt = (y1_r >= dbd_pkg::MIN_YEAR) && (y1_r <= dbd_pkg::MAX_YEAR) &&
             (m1_r >= dbd_pkg::MONTH_JAN) && (m1_r <= dbd_pkg::MONTH_DEC) &&
             (d1_r != '0) && (d1_r <= mlen);
    doy_nxt = dbd_pkg::days_before(m1_r) + dbd_pkg::DOY_W'(d1_r) +
              dbd_pkg::DOY_W'((m1_r > dbd_pkg::MONTH_FEB) && leap);
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      p2_r   <= p1_r;
      qp2_r  <= qp1_r;
      doy2_r <= doy_nxt;
      ok2_r  <= ok_nxt;
    end
  end

  // Stage 3: ordinal day number, 1 for the first day of year one.
  logic [dbd_pkg::ORD_W-1:0] ord_nxt;
  logic [dbd_pkg::ORD_W-1:0] ord3_r;
  logic                      ok3_r;

  assign ord_nxt = dbd_pkg::ORD_W'(p2_r) * dbd_pkg::ORD_W'(dbd_pkg::DAYS_PER_YEAR)
                 + dbd_pkg::ORD_W'(p2_r >> 2)
                 - dbd_pkg::ORD_W'(qp2_r)
                 + dbd_pkg::ORD_W'(qp2_r >> 2)
                 + dbd_pkg::ORD_W'(doy2_r);

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      ord3_r <= ord_nxt;
      ok3_r  <= ok2_r;
    end
  end

  assign ordinal = ord3_r;
  assign date_ok = ok3_r;

endmodule

>>> hdl/days_between_dates_unit.sv
// Channel   Port group   tdata (low bit up)                          tuser
// input     in_          start_year, start_month, start_day,         -
//                        end_year, end_month, end_day, 2 pad zeros
// output    out_         day_count, 2 pad zeros                      bad_date
//
// Four register stages: quotients by 100, leap and validity checks, ordinal
// day numbers, then the difference in the output register.
// One transfer per cycle in steady state while the output is not stalled.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles are squeezed out during an output stall.
// Reset clears only the valid bits.
module days_between_dates_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dbd_pkg::IN_DATA_W-1:0]     in_tdata,   // start_year, start_month,
                                                        // start_day, end_year,
                                                        // end_month, end_day
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dbd_pkg::OUT_DATA_W-1:0]    out_tdata,  // day_count
  output logic                              out_tuser   // bad_date
);

  logic [2:0] vld_r;
  logic [2:0] vld_nxt;
  logic       rdy1, rdy2, rdy3, rdy_out;
  logic       out_valid_r;
  dbd_pkg::ord_en_t en;

  assign rdy_out = !out_valid_r || out_tready;
  assign rdy3    = !vld_r[2] || rdy_out;
  assign rdy2    = !vld_r[1] || rdy3;
  assign rdy1    = !vld_r[0] || rdy2;

  assign in_tready = rdy1;
  assign en.ld1    = rdy1;
  assign en.ld2    = rdy2;
  assign en.ld3    = rdy3;

  always_comb begin
    vld_nxt[0] = rdy1 ? in_tvalid : vld_r[0];
    vld_nxt[1] = rdy2 ? vld_r[0]  : vld_r[1];
    vld_nxt[2] = rdy3 ? vld_r[1]  : vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rdy_out) begin
        out_valid_r <= vld_r[2];
      end
    end
  end

  logic [dbd_pkg::ORD_W-1:0] ord_a, ord_b;
  logic                      ok_a, ok_b;

  dbd_ordinal u_ord_start (
    .clk     (clk),
    .en      (en),
    .year    (in_tdata[13:0]),
    .month   (in_tdata[17:14]),
    .day     (in_tdata[22:18]),
    .ordinal (ord_a),
    .date_ok (ok_a)
  );

  dbd_ordinal u_ord_end (
    .clk     (clk),
    .en      (en),
    .year    (in_tdata[36:23]),
    .month   (in_tdata[40:37]),
    .day     (in_tdata[45:41]),
    .ordinal (ord_b),
    .date_ok (ok_b)
  );

  // Stage 4: absolute difference, forced to zero when either date is bad.
  logic [dbd_pkg::ORD_W-1:0]   diff;
  logic [dbd_pkg::COUNT_W-1:0] count_nxt;
  logic                        bad_nxt;
  logic [dbd_pkg::COUNT_W-1:0] count_r;
  logic                        bad_r;

  always_comb begin
    diff      = (ord_a <= ord_b) ? (ord_b - ord_a) : (ord_a - ord_b);
    bad_nxt   = !(ok_a && ok_b);
    count_nxt = bad_nxt ? '0 : diff[dbd_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dbd_pkg::OUT_DATA_W - dbd_pkg::COUNT_W){1'b0}}, count_r};
  assign out_tuser  = bad_r;

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[21:0] == '0)
    else $error("bad date result carries a nonzero day count");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:0] <= dbd_pkg::MAX_COUNT)
    else $error("day count beyond the span of valid dates");
`endif

endmodule

>>> test/tb_top.sv
module tb_top;

  typedef struct packed {
    logic [dbd_pkg::COUNT_W-1:0] days;
    logic                        bad;
  } gap_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dbd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [dbd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  gap_t pending_gaps[$];
  int   mismatches = 0;
  int   gaps_checked = 0;
  int   pairs_sent = 0;
  int   bad_pairs_sent = 0;
  int   input_stall_cycles = 0;
  bit   idling_on = 1'b1;
  int   sink_hold_cycles = 0;

  days_between_dates_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("days_between_dates_unit regression: fail");
    $finish;
  end

  // Calendar arithmetic used to predict each result.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == dbd_pkg::MONTH_FEB) return leap_year(y) ? 29 : 28;
    if (m == dbd_pkg::MONTH_APR || m == dbd_pkg::MONTH_JUN ||
        m == dbd_pkg::MONTH_SEP || m == dbd_pkg::MONTH_NOV) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    if (y < dbd_pkg::MIN_YEAR || y > dbd_pkg::MAX_YEAR) return 1'b0;
    if (m < dbd_pkg::MONTH_JAN || m > dbd_pkg::MONTH_DEC) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  function automatic int unsigned days_into_year(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      1:       n = 0;
      2:       n = 31;
      3:       n = 59;
      4:       n = 90;
      5:       n = 120;
      6:       n = 151;
      7:       n = 181;
      8:       n = 212;
      9:       n = 243;
      10:      n = 273;
      11:      n = 304;
      default: n = 334;
    endcase
    if (m > dbd_pkg::MONTH_FEB && leap_year(y)) n = n + 1;
    return n;
  endfunction

  // Count of days from the start of year 1, valid dates only.
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400 + days_into_year(y, m) + d;
  endfunction

  function automatic gap_t date_gap(input logic [dbd_pkg::IN_DATA_W-1:0] item);
    logic [dbd_pkg::YEAR_W-1:0]  y1, y2;
    logic [dbd_pkg::MONTH_W-1:0] m1, m2;
    logic [dbd_pkg::DAY_W-1:0]   d1, d2;
    int unsigned                 a, b;
    gap_t                        g;
    {d2, m2, y2, d1, m1, y1} =
      item[2*(dbd_pkg::YEAR_W+dbd_pkg::MONTH_W+dbd_pkg::DAY_W)-1:0];
    g.bad  = !(date_valid(y1, m1, d1) && date_valid(y2, m2, d2));
    g.days = '0;
    if (!g.bad) begin
      a = day_number(y1, m1, d1);
      b = day_number(y2, m2, d2);
      g.days = dbd_pkg::COUNT_W'((a > b) ? a - b : b - a);
    end
    return g;
  endfunction

  // Results are checked against the oldest prediction; each input transfer
  // queues a new prediction. Both sample on the rising edge.
  always @(posedge clk) begin : monitor
    gap_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_gaps.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: expected none, actual days=%0d bad=%0b",
                   $time, out_tdata[dbd_pkg::COUNT_W-1:0], out_tuser);
        end else begin
          want = pending_gaps.pop_front();
          gaps_checked++;
          if (out_tdata[dbd_pkg::COUNT_W-1:0] !== want.days) begin
            mismatches++;
            $display("%0t: day_count mismatch: expected %0d, actual %0d",
                     $time, want.days, out_tdata[dbd_pkg::COUNT_W-1:0]);
          end
          if (out_tuser !== want.bad) begin
            mismatches++;
            $display("%0t: bad_date mismatch: expected %0b, actual %0b",
                     $time, want.bad, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = date_gap(in_tdata);
        pending_gaps.push_back(want);
        pairs_sent++;
        if (want.bad) bad_pairs_sent++;
      end
      if (in_tvalid && !in_tready) input_stall_cycles++;
    end
  end

  // Output side: random stall bursts, plus a long hold-off when requested.
  initial begin : sink
    int burst;
    burst = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one date pair and returns after its transfer. Valid is left high
  // so that the next pair can follow without a bubble.
  task automatic send_dates(input int unsigned sy, input int unsigned sm,
                            input int unsigned sd, input int unsigned ey,
                            input int unsigned em, input int unsigned ed);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, dbd_pkg::DAY_W'(ed), dbd_pkg::MONTH_W'(em), dbd_pkg::YEAR_W'(ey),
                  dbd_pkg::DAY_W'(sd), dbd_pkg::MONTH_W'(sm), dbd_pkg::YEAR_W'(sy)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pick_date(output int unsigned y, output int unsigned m,
                           output int unsigned d);
    case ($urandom_range(0, 2))
      0: y = $urandom_range(1, 9999);
      1: begin
        y = $urandom_range(0, 99) * 100 + $urandom_range(0, 8);
        y = (y < 4) ? 1 : y - 4;
        if (y > 9999) y = 9999;
      end
      default: y = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(9995, 9999);
    endcase
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? month_days(m, y) : $urandom_range(1, month_days(m, y));
  endtask

  task automatic break_date(inout int unsigned y, inout int unsigned m, inout int unsigned d);
    case ($urandom_range(0, 4))
      0: y = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
      1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
      2: d = 0;
      3: d = (month_days(m, y) < 31) ? $urandom_range(month_days(m, y) + 1, 31) : 0;
      default: begin
        // February 29 in a common year, century years included.
        y = $urandom_range(0, 1) ? $urandom_range(0, 2499) * 4 + 1
                                 : $urandom_range(0, 24) * 400 + 100;
        m = dbd_pkg::MONTH_FEB;
        d = 29;
      end
    endcase
  endtask

  task automatic test_directed;
    send_dates(1, dbd_pkg::MONTH_JAN, 1, 9999, dbd_pkg::MONTH_DEC, 31);
    send_dates(9999, dbd_pkg::MONTH_DEC, 31, 1, dbd_pkg::MONTH_JAN, 1);
    send_dates(1, dbd_pkg::MONTH_JAN, 1, 1, dbd_pkg::MONTH_JAN, 1);
    send_dates(2024, dbd_pkg::MONTH_FEB, 29, 2024, dbd_pkg::MONTH_FEB, 29);
    send_dates(2000, dbd_pkg::MONTH_FEB, 29, 2000, 3, 1);
    send_dates(1900, dbd_pkg::MONTH_FEB, 29, 1900, 3, 1);
    send_dates(2004, dbd_pkg::MONTH_FEB, 29, 2003, dbd_pkg::MONTH_FEB, 28);
    send_dates(2001, dbd_pkg::MONTH_FEB, 29, 2001, 3, 1);
    send_dates(0, dbd_pkg::MONTH_JAN, 1, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2000, dbd_pkg::MONTH_JAN, 1, 10000, dbd_pkg::MONTH_JAN, 1);
    send_dates(16383, dbd_pkg::MONTH_DEC, 31, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2000, 0, 1, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2000, dbd_pkg::MONTH_JAN, 1, 2000, 13, 1);
    send_dates(2000, 15, 31, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2000, dbd_pkg::MONTH_JAN, 0, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2000, dbd_pkg::MONTH_JAN, 1, 2000, dbd_pkg::MONTH_APR, 31);
    send_dates(1999, dbd_pkg::MONTH_DEC, 31, 2000, dbd_pkg::MONTH_JAN, 1);
    send_dates(2020, 3, 5, 2020, dbd_pkg::MONTH_JAN, 20);
    send_dates(2020, 5, 31, 2020, 5, 1);
    send_dates(1, dbd_pkg::MONTH_JAN, 1, 1, dbd_pkg::MONTH_DEC, 31);
    send_dates(9999, dbd_pkg::MONTH_DEC, 31, 9999, dbd_pkg::MONTH_JAN, 1);
    send_dates(0, 0, 0, 16383, 15, 31);
    send_dates(2100, dbd_pkg::MONTH_FEB, 28, 2100, 3, 1);
  endtask

  // Mostly valid pairs, spread wide or close together, with a share of broken dates.
  task automatic test_random_dates(input int count);
    int unsigned sy, sm, sd, ey, em, ed;
    repeat (count) begin
      pick_date(sy, sm, sd);
      case ($urandom_range(0, 3))
        0: pick_date(ey, em, ed);
        1: begin
          ey = sy;
          em = $urandom_range(1, 12);
          ed = $urandom_range(1, month_days(em, ey));
        end
        2: begin
          ey = (sy == 1 || (sy < 9999 && $urandom_range(0, 1))) ? sy + 1 : sy - 1;
          em = $urandom_range(1, 12);
          ed = $urandom_range(1, month_days(em, ey));
        end
        default: begin
          ey = sy;
          em = sm;
          ed = $urandom_range(1, month_days(em, ey));
        end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) break_date(sy, sm, sd);
        else break_date(ey, em, ed);
      end
      send_dates(sy, sm, sd, ey, em, ed);
    end
  endtask

  // Every field drawn over its full bit width.
  task automatic test_raw_fields(input int count);
    repeat (count)
      send_dates($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endtask

  // The output holds off long enough for the pipeline to fill and stall the input.
  task automatic test_output_backpressure;
    idling_on = 1'b0;
    sink_hold_cycles = 300;
    test_random_dates(60);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_dates(1150);
    test_raw_fields(320);
    test_output_backpressure();
    test_random_dates(150);
    in_tvalid <= 1'b0;

    while (pending_gaps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d date pairs (%0d with an invalid date) and checked %0d results.",
             pairs_sent, bad_pairs_sent, gaps_checked);
    $display("The input was held off for %0d cycles by output stalls.", input_stall_cycles);
    if (mismatches == 0) begin
      $display("days_between_dates_unit regression: pass");
    end else begin
      $display("days_between_dates_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/dbd_pkg.sv
hdl/dbd_ordinal.sv
hdl/days_between_dates_unit.sv
test/tb_top.sv
